>>> sv/msf_tsd_pkg.sv
// Package for the MSF time signal bit decoder.
// Holds the segment and result types and the division-count constants.
// No dependencies.
package msf_tsd_pkg;

  localparam int DivW = 4;
  localparam int SecW = 8;

  localparam logic [DivW-1:0] DIV_ONE    = 4'd1;
  localparam logic [DivW-1:0] DIV_TWO    = 4'd2;
  localparam logic [DivW-1:0] DIV_THREE  = 4'd3;
  localparam logic [DivW-1:0] DIV_MARK   = 4'd5;
  localparam logic [DivW-1:0] DIV_ON_1X  = 4'd7;
  localparam logic [DivW-1:0] DIV_ON_10  = 4'd8;
  localparam logic [DivW-1:0] DIV_ON_00  = 4'd9;

  localparam logic signed [SecW-1:0] SEC_NONE = -8'sd1;
  localparam logic signed [SecW-1:0] SEC_MAX  = 8'sd127;
  localparam logic signed [SecW-1:0] SEC_ZERO = 8'sd0;
  localparam logic signed [SecW-1:0] SEC_ONE  = 8'sd1;

  typedef struct packed {
    logic            carrier_on;
    logic [DivW-1:0] div_count;
  } seg_t;

  typedef struct packed {
    logic signed [SecW-1:0] seconds_number;
    logic                   bit_a;
    logic                   bit_b;
    logic                   locked;
    logic                   pair_ready;
  } res_t;

endpackage

>>> sv/msf_tsd_in_reg.sv
// Input register for the MSF time signal bit decoder.
// Holds one carrier segment until the decode stage takes it; uses msf_tsd_pkg.
module msf_tsd_in_reg
  import msf_tsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  seg_t in_seg,
  input  logic advance,
  output logic seg_vld,
  output seg_t seg
);

  logic vld_r;
  logic vld_nxt;
  seg_t seg_r;
  logic load;

  assign in_stall = vld_r & ~advance;
  assign load     = in_valid & ~in_stall;
  assign vld_nxt  = load | (vld_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      seg_r <= in_seg;
    end
  end

  assign seg_vld = vld_r;
  assign seg     = seg_r;

endmodule

>>> sv/msf_tsd_core.sv
// Decode state machine of the MSF time signal bit decoder.
// Classifies one segment per cycle while advance is high and updates sync, count and bits; uses msf_tsd_pkg.
module msf_tsd_core
  import msf_tsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  seg_t seg,
  output res_t res
);

  typedef enum logic [2:0] {
    ST_MARK_START = 3'd0,
    ST_MARK_END   = 3'd1,
    ST_NEXT_SEC   = 3'd2,
    ST_END_11     = 3'd3,
    ST_END_10     = 3'd4,
    ST_0X_ON      = 3'd5,
    ST_01_OFF     = 3'd6,
    ST_END_01     = 3'd7
  } state_t;

  state_t                 state_r, state_nxt;
  logic signed [SecW-1:0] count_r, count_nxt;
  logic                   lock_r, lock_nxt;
  logic                   bit_a_r, bit_a_nxt;
  logic                   bit_b_r, bit_b_nxt;
  logic                   ready;
  logic                   take;
  logic                   take_a;
  logic                   take_b;
  logic                   on;
  logic [DivW-1:0]        d;
  logic signed [SecW-1:0] count_inc;

  assign on        = seg.carrier_on;
  assign d         = seg.div_count;
  assign count_inc = (count_r == SEC_MAX) ? count_r : count_r + SEC_ONE;

  always_comb begin
    state_nxt = ST_MARK_START;
    count_nxt = count_r;
    lock_nxt  = lock_r;
    bit_a_nxt = bit_a_r;
    bit_b_nxt = bit_b_r;
    ready     = 1'b0;
    take      = 1'b0;
    take_a    = 1'b0;
    take_b    = 1'b0;
    case (state_r)
      ST_MARK_END: begin
        if (on && d == DIV_MARK) begin
          lock_nxt  = 1'b1;
          count_nxt = SEC_ZERO;
          bit_a_nxt = 1'b1;
          bit_b_nxt = 1'b1;
          state_nxt = ST_NEXT_SEC;
          ready     = 1'b1;
        end
      end
      ST_NEXT_SEC: begin
        if (!on) begin
          if (d == DIV_ONE) begin
            state_nxt = ST_0X_ON;
          end else if (d == DIV_TWO) begin
            state_nxt = ST_END_10;
          end else if (d == DIV_THREE) begin
            state_nxt = ST_END_11;
          end else if (d == DIV_MARK) begin
            state_nxt = ST_MARK_END;
          end
        end
      end
      ST_END_11: begin
        if (on && d == DIV_ON_1X) begin
          take   = 1'b1;
          take_a = 1'b1;
          take_b = 1'b1;
        end
      end
      ST_END_10: begin
        if (on && d == DIV_ON_10) begin
          take   = 1'b1;
          take_a = 1'b1;
        end
      end
      ST_0X_ON: begin
        if (on && d == DIV_ON_00) begin
          take = 1'b1;
        end else if (on && d == DIV_ONE) begin
          state_nxt = ST_01_OFF;
        end
      end
      ST_01_OFF: begin
        if (!on && d == DIV_ONE) begin
          state_nxt = ST_END_01;
        end
      end
      ST_END_01: begin
        if (on && d == DIV_ON_1X) begin
          take   = 1'b1;
          take_b = 1'b1;
        end
      end
      default: begin
        lock_nxt  = 1'b0;
        count_nxt = SEC_NONE;
        if (!on && d == DIV_MARK) begin
          state_nxt = ST_MARK_END;
        end
      end
    endcase
    if (take) begin
      bit_a_nxt = take_a;
      bit_b_nxt = take_b;
      count_nxt = count_inc;
      state_nxt = ST_NEXT_SEC;
      ready     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MARK_START;
      count_r <= SEC_NONE;
      lock_r  <= 1'b0;
      bit_a_r <= 1'b0;
      bit_b_r <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      lock_r  <= lock_nxt;
      bit_a_r <= bit_a_nxt;
      bit_b_r <= bit_b_nxt;
    end
  end

  assign res.seconds_number = count_nxt;
  assign res.bit_a          = bit_a_nxt;
  assign res.bit_b          = bit_b_nxt;
  assign res.locked         = lock_nxt;
  assign res.pair_ready     = ready;

  // Every second-decoding state is reachable only through a completed marker.
  a_lock_in_sec_states: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_MARK_START && state_r != ST_MARK_END) |-> lock_r)
    else $error("decode state past the marker without lock");

  a_lock_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r |-> (count_r != SEC_NONE))
    else $error("locked while the seconds count is unset");

  a_pair_when_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ready) |=> (lock_r && state_r == ST_NEXT_SEC))
    else $error("new bit pair without lock");

endmodule

>>> sv/msf_tsd_out_reg.sv
// Result register for the MSF time signal bit decoder.
// Holds one result until the receiver takes it; uses msf_tsd_pkg.
module msf_tsd_out_reg
  import msf_tsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_vld,
  input  res_t res,
  output logic can_load,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic vld_r;
  logic vld_nxt;
  res_t res_r;
  logic load;

  assign can_load = ~vld_r | ~out_stall;
  assign load     = res_vld & can_load;
  assign vld_nxt  = load | (vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

>>> sv/msf_time_signal_bit_decoder_unit.sv
// Top level of the MSF time signal bit decoder.
// Instantiates msf_tsd_in_reg, msf_tsd_core and msf_tsd_out_reg; uses msf_tsd_pkg.
//
// Each request is one finished carrier segment (level and length in 100 ms
// divisions) and yields exactly one result: the seconds count since the minute
// marker (-1 while unsynchronized, saturating at 127), the latest A and B bits,
// the lock flag, and a flag for a segment that completed a new A/B pair. The
// block takes one segment per clock while the receiver does not stall. A
// request is held in the input register, then passes through the
// combinational next-state logic into the result register, where it waits
// until the receiver takes it. A lost sync clears the count and lock on the
// following segment.
module msf_time_signal_bit_decoder_unit
  import msf_tsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_carrier_on,
  input  logic [DivW-1:0]        in_div_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [SecW-1:0] out_seconds_number,
  output logic                   out_bit_a,
  output logic                   out_bit_b,
  output logic                   out_locked,
  output logic                   out_pair_ready
);

  seg_t in_seg;
  seg_t seg;
  logic seg_vld;
  logic can_load;
  logic advance;
  res_t res;
  res_t out_res;

  assign in_seg.carrier_on = in_carrier_on;
  assign in_seg.div_count  = in_div_count;
  assign advance           = seg_vld & can_load;

  msf_tsd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_seg   (in_seg),
    .advance  (advance),
    .seg_vld  (seg_vld),
    .seg      (seg)
  );

  msf_tsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .seg     (seg),
    .res     (res)
  );

  msf_tsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (seg_vld),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_seconds_number = out_res.seconds_number;
  assign out_bit_a          = out_res.bit_a;
  assign out_bit_b          = out_res.bit_b;
  assign out_locked         = out_res.locked;
  assign out_pair_ready     = out_res.pair_ready;

endmodule
